FILE: hw/rtl/ffsa_pkg.sv
// ----------------------------------------------------------------------------
// ffsa_pkg
// Shared types and operation codes of the first-fit segment allocator.
// ----------------------------------------------------------------------------
package ffsa_pkg;

  // operation codes
  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_CHECK = 2'd2,
    OP_BASE  = 2'd3
  } op_e;

  // datapath commands issued by the controller
  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,       // capture item, clear scan results
    CMD_OWN_SCAN,   // examine owner row at scan index
    CMD_HOLE_SCAN,  // examine hole at scan index
    CMD_ALLOC_DO,   // write owner row, trim hole
    CMD_DEL_STEP,   // move hole up by one (delete)
    CMD_INS_STEP,   // move hole down by one (insert)
    CMD_INS_PUT,    // place freed hole, release owner row
    CMD_MERGE_STEP, // examine adjacent pair at scan index
    CMD_CHECK_DO,   // finish address check
    CMD_REL_ONLY    // release owner row without a new hole
  } cmd_e;

  // control from controller to datapath
  typedef struct packed {
    cmd_e cmd;
    logic idx_clr;   // reset scan index
    logic idx_inc;   // advance scan index
    logic idx_dec;   // step scan index down
    logic idx_tot;   // load scan index with hole count
    logic idx_pos;   // load scan index with found hole
  } ffsa_ctl_t;

  // status from datapath to controller
  typedef struct packed {
    op_e  op;
    logic own_end;    // owner scan done
    logic own_hit;    // owner row found
    logic row_free;   // free owner row found
    logic hole_end;   // scan index reached hole count
    logic hole_hit;   // fitting or insert position found
    logic exact;      // found hole equals request
    logic req_zero;
    logic store_full;
    logic idx_at_pos; // insert shift reached position
    logic pair_end;   // no pair left at scan index
    logic pair_join;  // pair at scan index touches
  } ffsa_sts_t;

endpackage

FILE: hw/rtl/first_fit_segment_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_segment_allocator
// First-fit memory segment allocator with hole merging.
// ----------------------------------------------------------------------------
// One item is processed at a time by a sequencer over the owner table and
// hole list: the accept step, a scan of the owners, a hole scan and its
// shift, a merge pass after a free, and a final step that loads the
// result. The result sits in an output register; the next item is taken
// once that register has been loaded, so a stalled output holds the
// sequencer in its done state.
module first_fit_segment_allocator #(
  parameter int unsigned TABLE_ENTRIES = 16,
  parameter int unsigned ADDR_WIDTH    = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,    // memory_size
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // op[1:0], owner_id[9:2],
                                      // request_size[25:10], address[41:26]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata    // ok[0], segment_base[16:1]
);

  ffsa_pkg::ffsa_ctl_t ctl;
  ffsa_pkg::ffsa_sts_t sts;
  logic        load, res_ok;
  logic [15:0] res_base;
  logic        out_v_q;
  logic        out_ok_q;
  logic [15:0] out_base_q;

  ffsa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .out_load_o (load),
    .out_busy_i (out_v_q && !m_axis_tready),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  ffsa_dp #(
    .TableEntries (TABLE_ENTRIES),
    .AddrWidth    (ADDR_WIDTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .op_i        (s_axis_tdata[1:0]),
    .owner_i     (s_axis_tdata[9:2]),
    .size_i      (s_axis_tdata[25:10]),
    .addr_i      (s_axis_tdata[41:26]),
    .ctl_i       (ctl),
    .sts_o       (sts),
    .res_ok_o    (res_ok),
    .res_base_o  (res_base)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (load) begin
      out_v_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_ok_q   <= res_ok;
      out_base_q <= res_base;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {7'd0, out_base_q, out_ok_q};

`ifndef SYNTHESIS
  // a waiting result holds until taken
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped");
  // the tdata pad stays zero
  a_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tdata[23:17] == 7'd0) else $error("pad bits set");
  // no new item while a result is being loaded
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> !s_axis_tready) else $error("overlap");
`endif

endmodule

FILE: hw/rtl/ffsa_ctrl.sv
// ----------------------------------------------------------------------------
// ffsa_ctrl
// Sequencer of the allocator: scans, shifts and merges step by step.
// ----------------------------------------------------------------------------
module ffsa_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_load_o,
  input  logic               out_busy_i,
  input  ffsa_pkg::ffsa_sts_t sts_i,
  output ffsa_pkg::ffsa_ctl_t ctl_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_OWN, S_HOLE, S_DECIDE, S_DEL, S_INS, S_MERGE, S_DONE
  } state_e;

  state_e state_q, state_d;

  // next state and commands
  always_comb begin
    state_d    = state_q;
    ctl_o      = '0;
    ctl_o.cmd  = ffsa_pkg::CMD_NONE;
    out_load_o = 1'b0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctl_o.cmd     = ffsa_pkg::CMD_LOAD;
          ctl_o.idx_clr = 1'b1;
          state_d       = S_OWN;
        end
      end
      S_OWN: begin
        if (sts_i.own_end) begin
          ctl_o.idx_clr = 1'b1;
          if (sts_i.op == ffsa_pkg::OP_ALLOC) begin
            state_d = S_HOLE;
          end else if (sts_i.op == ffsa_pkg::OP_FREE && sts_i.own_hit) begin
            state_d = S_HOLE;
          end else begin
            ctl_o.cmd = ffsa_pkg::CMD_CHECK_DO;
            state_d   = S_DONE;
          end
        end else begin
          ctl_o.cmd     = ffsa_pkg::CMD_OWN_SCAN;
          ctl_o.idx_inc = 1'b1;
        end
      end
      S_HOLE: begin
        if (sts_i.hole_hit || sts_i.hole_end) begin
          state_d = S_DECIDE;
        end else begin
          ctl_o.cmd     = ffsa_pkg::CMD_HOLE_SCAN;
          ctl_o.idx_inc = 1'b1;
        end
      end
      S_DECIDE: begin
        if (sts_i.op == ffsa_pkg::OP_ALLOC) begin
          if (!sts_i.req_zero && sts_i.hole_hit && sts_i.row_free) begin
            ctl_o.cmd     = ffsa_pkg::CMD_ALLOC_DO;
            ctl_o.idx_pos = 1'b1;
            state_d       = sts_i.exact ? S_DEL : S_DONE;
          end else begin
            state_d = S_DONE;
          end
        end else if (sts_i.store_full) begin
          ctl_o.cmd = ffsa_pkg::CMD_REL_ONLY;
          state_d   = S_DONE;
        end else begin
          ctl_o.idx_tot = 1'b1;
          state_d       = S_INS;
        end
      end
      S_DEL: begin
        if (sts_i.hole_end) begin
          state_d = S_DONE;
        end else begin
          ctl_o.cmd     = ffsa_pkg::CMD_DEL_STEP;
          ctl_o.idx_inc = 1'b1;
        end
      end
      S_INS: begin
        if (sts_i.idx_at_pos) begin
          ctl_o.cmd     = ffsa_pkg::CMD_INS_PUT;
          ctl_o.idx_clr = 1'b1;
          state_d       = S_MERGE;
        end else begin
          ctl_o.cmd     = ffsa_pkg::CMD_INS_STEP;
          ctl_o.idx_dec = 1'b1;
        end
      end
      S_MERGE: begin
        if (sts_i.pair_end) begin
          state_d = S_DONE;
        end else begin
          ctl_o.cmd     = ffsa_pkg::CMD_MERGE_STEP;
          ctl_o.idx_inc = !sts_i.pair_join;
        end
      end
      S_DONE: begin
        if (!out_busy_i) begin
          out_load_o = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

`ifndef SYNTHESIS
  // a result is loaded only when the output stage is free
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load_o |-> !out_busy_i) else $error("load into busy output");
  // a new item is taken only in idle
  a_take_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_ready_o && in_valid_i) |=> state_q == S_OWN) else $error("bad start");
  // after a load the sequencer is idle again
  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load_o |=> in_ready_o) else $error("not idle after result");
`endif

endmodule

FILE: hw/rtl/ffsa_dp.sv
// ----------------------------------------------------------------------------
// ffsa_dp
// Datapath: owner table, hole list, scan index and result register.
// ----------------------------------------------------------------------------
module ffsa_dp #(
  parameter int unsigned TableEntries = 16,
  parameter int unsigned AddrWidth    = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [15:0]         cfg_wdata_i,
  input  logic [1:0]          op_i,
  input  logic [7:0]          owner_i,
  input  logic [15:0]         size_i,
  input  logic [15:0]         addr_i,
  input  ffsa_pkg::ffsa_ctl_t ctl_i,
  output ffsa_pkg::ffsa_sts_t sts_o,
  output logic                res_ok_o,
  output logic [15:0]         res_base_o
);

  localparam int unsigned HoleDepth = TableEntries + 1;
  localparam int unsigned IdxW = $clog2(HoleDepth + 1);
  localparam int unsigned RowW = $clog2(TableEntries);
  localparam int unsigned SzW  = AddrWidth + 1;

  // owner table and hole list
  logic                 own_v_q [TableEntries];
  logic [7:0]           own_id_q [TableEntries];
  logic [AddrWidth-1:0] own_base_q [TableEntries];
  logic [15:0]          own_size_q [TableEntries];
  logic [AddrWidth-1:0] h_base_q [HoleDepth];
  logic [SzW-1:0]       h_size_q [HoleDepth];
  logic [IdxW-1:0]      total_q, idx_q, pos_q;

  // captured item and scan results
  logic [1:0]           op_q;
  logic [7:0]           owner_q;
  logic [15:0]          size_q;
  logic [15:0]          addr_q;
  logic                 own_hit_q, row_free_q, hole_hit_q;
  logic [RowW-1:0]      own_row_q, free_row_q;

  logic [RowW-1:0]      row_idx;
  logic [IdxW-1:0]      nxt_idx;
  logic                 own_end;
  logic [AddrWidth-1:0] ins_base;
  logic [SzW-1:0]       ins_size;
  logic [SzW:0]         pair_end_addr, pair_sum, pair_room;
  logic [SzW-1:0]       seg_end;

  assign own_end  = idx_q >= IdxW'(TableEntries);
  assign row_idx  = idx_q[RowW-1:0];
  assign nxt_idx  = idx_q + IdxW'(1);
  assign ins_base = own_base_q[own_row_q];
  assign ins_size = SzW'(own_size_q[own_row_q]);
  assign pair_end_addr = (SzW+1)'(h_base_q[idx_q]) + (SzW+1)'(h_size_q[idx_q]);
  assign pair_sum  = (SzW+1)'(h_size_q[idx_q]) + (SzW+1)'(h_size_q[nxt_idx]);
  assign pair_room = ((SzW+1)'(1) << AddrWidth) - (SzW+1)'(h_base_q[idx_q]);
  assign seg_end   = SzW'(own_base_q[own_row_q]) + SzW'(own_size_q[own_row_q]);

  // status toward the controller
  always_comb begin
    sts_o            = '0;
    sts_o.op         = ffsa_pkg::op_e'(op_q);
    sts_o.own_end    = own_end;
    sts_o.own_hit    = own_hit_q;
    sts_o.row_free   = row_free_q;
    sts_o.hole_end   = idx_q >= total_q;
    sts_o.hole_hit   = hole_hit_q;
    sts_o.exact      = h_size_q[pos_q] == SzW'(size_q);
    sts_o.req_zero   = size_q == '0;
    sts_o.store_full = total_q >= IdxW'(HoleDepth);
    sts_o.idx_at_pos = idx_q <= pos_q;
    sts_o.pair_end   = nxt_idx >= total_q;
    sts_o.pair_join  = pair_end_addr == (SzW+1)'(h_base_q[nxt_idx]);
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TableEntries; i++) own_v_q[i] <= 1'b0;
      total_q    <= IdxW'(1);
      idx_q      <= '0;
      pos_q      <= '0;
      op_q       <= '0;
      own_hit_q  <= 1'b0;
      row_free_q <= 1'b0;
      hole_hit_q <= 1'b0;
      res_ok_o   <= 1'b0;
    end else begin
      // scan index
      if (ctl_i.idx_clr) idx_q <= '0;
      else if (ctl_i.idx_inc) idx_q <= nxt_idx;
      else if (ctl_i.idx_dec) idx_q <= idx_q - IdxW'(1);
      else if (ctl_i.idx_tot) idx_q <= total_q;
      else if (ctl_i.idx_pos) idx_q <= pos_q;
      if (cfg_we_i) begin
        total_q <= (cfg_wdata_i == '0) ? '0 : IdxW'(1);
      end
      unique case (ctl_i.cmd)
        ffsa_pkg::CMD_LOAD: begin
          op_q       <= op_i;
          own_hit_q  <= 1'b0;
          row_free_q <= 1'b0;
          hole_hit_q <= 1'b0;
          res_ok_o   <= 1'b0;
        end
        ffsa_pkg::CMD_OWN_SCAN: begin
          if (!own_v_q[row_idx] && !row_free_q) begin
            row_free_q <= 1'b1;
          end
          if (own_v_q[row_idx] && own_id_q[row_idx] == owner_q && !own_hit_q) begin
            own_hit_q <= 1'b1;
            res_ok_o  <= op_q == ffsa_pkg::OP_FREE || op_q == ffsa_pkg::OP_BASE;
          end
        end
        ffsa_pkg::CMD_HOLE_SCAN: begin
          if (op_q == ffsa_pkg::OP_ALLOC) begin
            if (h_size_q[idx_q] >= SzW'(size_q)) begin
              hole_hit_q <= 1'b1;
              pos_q      <= idx_q;
            end
          end else if (idx_q == '0 ? h_base_q[0] > ins_base
                                   : h_base_q[idx_q] >= ins_base) begin
            hole_hit_q <= 1'b1;
            pos_q      <= idx_q;
          end
          if (op_q != ffsa_pkg::OP_ALLOC && nxt_idx >= total_q &&
              !(idx_q == '0 ? h_base_q[0] > ins_base : h_base_q[idx_q] >= ins_base)) begin
            pos_q <= nxt_idx;
          end
        end
        ffsa_pkg::CMD_ALLOC_DO: begin
          own_v_q[free_row_q] <= 1'b1;
          res_ok_o            <= 1'b1;
          if (h_size_q[pos_q] == SzW'(size_q)) begin
            total_q <= total_q - IdxW'(1);
          end
        end
        ffsa_pkg::CMD_INS_PUT: begin
          own_v_q[own_row_q] <= 1'b0;
          total_q            <= total_q + IdxW'(1);
        end
        ffsa_pkg::CMD_REL_ONLY: own_v_q[own_row_q] <= 1'b0;
        ffsa_pkg::CMD_MERGE_STEP: begin
          if (sts_o.pair_join) total_q <= total_q - IdxW'(1);
        end
        ffsa_pkg::CMD_CHECK_DO: begin
          if (op_q == ffsa_pkg::OP_CHECK) begin
            res_ok_o <= own_hit_q && SzW'(addr_q) >= SzW'(ins_base) &&
                        SzW'(addr_q) < seg_end;
          end
        end
        default: ;
      endcase
      // an insert scan that ran off the end places the hole last
      if (ctl_i.cmd == ffsa_pkg::CMD_NONE && op_q == ffsa_pkg::OP_FREE &&
          !hole_hit_q && idx_q >= total_q && ctl_i.idx_tot) begin
        pos_q <= total_q;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owner_q    <= '0;
      size_q     <= '0;
      addr_q     <= '0;
      res_base_o <= '0;
      free_row_q <= '0;
      own_row_q  <= '0;
      for (int i = 0; i < TableEntries; i++) begin
        own_id_q[i]   <= '0;
        own_base_q[i] <= '0;
        own_size_q[i] <= '0;
      end
      // one full hole of the default memory size
      for (int k = 0; k < HoleDepth; k++) begin
        h_base_q[k] <= '0;
        h_size_q[k] <= '0;
      end
      h_size_q[0] <= SzW'(1024);
    end else begin
      if (ctl_i.cmd == ffsa_pkg::CMD_LOAD) begin
        owner_q    <= owner_i;
        size_q     <= size_i;
        addr_q     <= addr_i;
        res_base_o <= '0;
      end
      if (ctl_i.cmd == ffsa_pkg::CMD_OWN_SCAN) begin
        if (!own_v_q[row_idx] && !row_free_q) free_row_q <= row_idx;
        if (own_v_q[row_idx] && own_id_q[row_idx] == owner_q && !own_hit_q) begin
          own_row_q <= row_idx;
          if (op_q != ffsa_pkg::OP_ALLOC) res_base_o <= 16'(own_base_q[row_idx]);
        end
      end
      if (cfg_we_i) begin
        h_base_q[0] <= '0;
        h_size_q[0] <= SzW'(cfg_wdata_i);
      end else begin
        unique case (ctl_i.cmd)
          ffsa_pkg::CMD_ALLOC_DO: begin
            own_id_q[free_row_q]   <= owner_q;
            own_base_q[free_row_q] <= h_base_q[pos_q];
            own_size_q[free_row_q] <= size_q;
            res_base_o             <= 16'(h_base_q[pos_q]);
            h_base_q[pos_q]        <= h_base_q[pos_q] + AddrWidth'(size_q);
            h_size_q[pos_q]        <= h_size_q[pos_q] - SzW'(size_q);
          end
          ffsa_pkg::CMD_DEL_STEP: begin
            h_base_q[idx_q] <= h_base_q[nxt_idx];
            h_size_q[idx_q] <= h_size_q[nxt_idx];
          end
          ffsa_pkg::CMD_INS_STEP: begin
            h_base_q[idx_q] <= h_base_q[idx_q - IdxW'(1)];
            h_size_q[idx_q] <= h_size_q[idx_q - IdxW'(1)];
          end
          ffsa_pkg::CMD_INS_PUT: begin
            h_base_q[pos_q] <= ins_base;
            h_size_q[pos_q] <= ins_size;
          end
          ffsa_pkg::CMD_MERGE_STEP: begin
            if (sts_o.pair_join) begin
              h_size_q[idx_q] <= (pair_sum > pair_room) ? SzW'(pair_room) : SzW'(pair_sum);
              // close the gap left by the absorbed hole
              for (int k = 0; k < HoleDepth - 1; k++) begin
                if (IdxW'(k) > idx_q) begin
                  h_base_q[k] <= h_base_q[k+1];
                  h_size_q[k] <= h_size_q[k+1];
                end
              end
            end
          end
          default: ;
        endcase
      end
    end
  end

`ifndef SYNTHESIS
  // hole count never exceeds the list depth
  a_total_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= IdxW'(HoleDepth)) else $error("hole count overflow");
  // a configuration write leaves at most one hole
  a_cfg_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> total_q <= IdxW'(1)) else $error("config did not reset holes");
  // insert never starts with a full list
  a_ins_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.cmd == ffsa_pkg::CMD_INS_PUT |-> total_q < IdxW'(HoleDepth))
    else $error("insert into full list");
`endif

endmodule

FILE: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the first-fit segment allocator: items are
// predicted when they are queued, driven with random gaps, and every result
// is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_ROWS   = 16;
  localparam int HOLE_SLOTS = NUM_ROWS + 1;
  localparam longint SPACE  = 64'd65536;
  localparam int WATCH_MAX  = 5000;

  typedef struct packed {
    logic [15:0]   address;
    logic [15:0]   req_size;
    logic [7:0]    owner;
    ffsa_pkg::op_e op;
  } alloc_req_t;

  typedef struct packed {
    logic [15:0] base;
    logic        ok;
  } alloc_rsp_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [15:0] cfg_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;

  first_fit_segment_allocator u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // shadow allocator state
  logic   row_used [NUM_ROWS];
  int     row_owner [NUM_ROWS];
  longint row_base [NUM_ROWS];
  longint row_size [NUM_ROWS];
  longint hole_base [HOLE_SLOTS];
  longint hole_size [HOLE_SLOTS];
  int     hole_cnt;
  longint mem_words;

  alloc_req_t pending_items [$];
  alloc_rsp_t expected_rsps [$];

  int  errors = 0;
  bit  quiet_mode = 1'b0;
  int  hold_off = 0;
  int  idle_cycles = 0;
  bit  in_taken = 1'b0;
  bit  out_taken = 1'b0;

  // hole list back to one full hole, or to no hole for a zero memory size
  task automatic holes_reset();
    for (int k = 0; k < HOLE_SLOTS; k++) begin
      hole_base[k] = 0;
      hole_size[k] = 0;
    end
    if (mem_words == 0) begin
      hole_cnt = 0;
    end else begin
      hole_size[0] = mem_words;
      hole_cnt = 1;
    end
  endtask

  task automatic hole_remove(int idx);
    for (int k = idx; k + 1 < hole_cnt; k++) begin
      hole_base[k] = hole_base[k+1];
      hole_size[k] = hole_size[k+1];
    end
    hole_cnt--;
    hole_base[hole_cnt] = 0;
    hole_size[hole_cnt] = 0;
  endtask

  // insert in address order, then merge holes that touch exactly
  task automatic hole_return(longint b, longint s);
    int pos;
    int i;
    longint sum;
    longint room;
    if (hole_cnt >= HOLE_SLOTS) return;
    if (hole_cnt == 0 || hole_base[0] > b) begin
      pos = 0;
    end else begin
      pos = 1;
      while (pos < hole_cnt && hole_base[pos] < b) pos++;
    end
    for (int k = hole_cnt; k > pos; k--) begin
      hole_base[k] = hole_base[k-1];
      hole_size[k] = hole_size[k-1];
    end
    hole_base[pos] = b;
    hole_size[pos] = s;
    hole_cnt++;
    i = 0;
    while (i + 1 < hole_cnt) begin
      if (hole_base[i] + hole_size[i] == hole_base[i+1]) begin
        sum = hole_size[i] + hole_size[i+1];
        room = (SPACE > hole_base[i]) ? SPACE - hole_base[i] : 0;
        hole_size[i] = (sum > room) ? room : sum;
        hole_remove(i + 1);
      end else begin
        i++;
      end
    end
  endtask

  function automatic int find_row(int who);
    for (int i = 0; i < NUM_ROWS; i++)
      if (row_used[i] && row_owner[i] == who) return i;
    return -1;
  endfunction

  // compute the result of one item and update the shadow state
  task automatic predict_item(alloc_req_t it, output alloc_rsp_t r);
    int h;
    int fr;
    int row;
    longint req;
    longint adr;
    r = '0;
    req = it.req_size;
    adr = it.address;
    if (it.op == ffsa_pkg::OP_ALLOC) begin
      h = 0;
      while (h < hole_cnt && hole_size[h] < req) h++;
      fr = -1;
      for (int i = NUM_ROWS - 1; i >= 0; i--) if (!row_used[i]) fr = i;
      if (req != 0 && h < hole_cnt && fr >= 0) begin
        r.base = hole_base[h][15:0];
        r.ok = 1'b1;
        row_used[fr] = 1'b1;
        row_owner[fr] = it.owner;
        row_base[fr] = hole_base[h];
        row_size[fr] = req;
        if (hole_size[h] == req) begin
          hole_remove(h);
        end else begin
          hole_base[h] += req;
          hole_size[h] -= req;
        end
      end
    end else begin
      row = find_row(it.owner);
      if (row >= 0) begin
        r.base = row_base[row][15:0];
        case (it.op)
          ffsa_pkg::OP_FREE: begin
            hole_return(row_base[row], row_size[row]);
            row_used[row] = 1'b0;
            row_owner[row] = 0;
            row_base[row] = 0;
            row_size[row] = 0;
            r.ok = 1'b1;
          end
          ffsa_pkg::OP_CHECK: begin
            r.ok = (adr >= row_base[row] && adr < row_base[row] + row_size[row]);
          end
          default: begin
            r.ok = 1'b1;
          end
        endcase
      end
    end
  endtask

  task automatic queue_item(ffsa_pkg::op_e op, int who, int req, int adr);
    alloc_req_t it;
    alloc_rsp_t r;
    it.op = op;
    it.owner = who[7:0];
    it.req_size = req[15:0];
    it.address = adr[15:0];
    predict_item(it, r);
    pending_items.push_back(it);
    expected_rsps.push_back(r);
  endtask

  // mostly small owner pool and fitting sizes, with full-range noise
  task automatic queue_random();
    int who;
    int req;
    int adr;
    int pick;
    int row;
    ffsa_pkg::op_e op;
    who = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 5) : $urandom_range(0, 255);
    pick = $urandom_range(0, 99);
    if (pick < 35) op = ffsa_pkg::OP_ALLOC;
    else if (pick < 65) op = ffsa_pkg::OP_FREE;
    else if (pick < 85) op = ffsa_pkg::OP_CHECK;
    else op = ffsa_pkg::OP_BASE;
    pick = $urandom_range(0, 9);
    if (pick == 0) req = 0;
    else if (pick < 3) req = $urandom_range(0, 65535);
    else req = $urandom_range(1, (mem_words / 8) + 2);
    row = find_row(who);
    if (row >= 0 && $urandom_range(0, 3) != 0)
      adr = int'(row_base[row]) + $urandom_range(0, int'(row_size[row])) - $urandom_range(0, 1);
    else
      adr = $urandom_range(0, 65535);
    queue_item(op, who, req, adr);
  endtask

  task automatic wait_drained();
    while (pending_items.size() != 0 || expected_rsps.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  task automatic write_mem_size(int v);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_wdata_i = v[15:0];
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    mem_words = v & 16'hffff;
    holes_reset();
  endtask

  // input driver
  int in_gap = 0;
  bit in_busy = 1'b0;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_taken) begin
        in_busy = 1'b0;
        in_taken = 1'b0;
      end
      if (!in_busy) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (pending_items.size() != 0) begin
          s_axis_tdata = {6'b0, pending_items.pop_front()};
          in_busy = 1'b1;
          in_gap = quiet_mode ? 0 : $urandom_range(0, 10);
        end
      end
      s_axis_tvalid = in_busy;
    end
  end

  // output ready with per-item stalls and long hold-offs
  int out_gap = 0;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_taken) begin
        out_taken = 1'b0;
        out_gap = quiet_mode ? 0 : $urandom_range(0, 10);
      end
      if (hold_off > 0) begin
        hold_off--;
        m_axis_tready = 1'b0;
      end else if (out_gap > 0) begin
        out_gap--;
        m_axis_tready = 1'b0;
      end else begin
        m_axis_tready = 1'b1;
      end
    end
  end

  // sample handshakes, check results, watchdog
  always @(posedge clk_i) begin
    alloc_rsp_t got;
    alloc_rsp_t want;
    if (rst_ni) begin
      idle_cycles++;
      if (s_axis_tvalid && s_axis_tready) begin
        in_taken = 1'b1;
        idle_cycles = 0;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        out_taken = 1'b1;
        idle_cycles = 0;
        got = m_axis_tdata[16:0];
        if (expected_rsps.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result ok=%0d base=%0d", got.ok, got.base);
        end else begin
          want = expected_rsps.pop_front();
          if (got.ok !== want.ok || got.base !== want.base) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: expected ok=%0d base=%0d, got ok=%0d base=%0d",
                       want.ok, want.base, got.ok, got.base);
          end
        end
      end
      if (idle_cycles >= WATCH_MAX) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // stimulus
  initial begin
    int sizes [6];
    for (int i = 0; i < NUM_ROWS; i++) begin
      row_used[i] = 1'b0;
      row_owner[i] = 0;
      row_base[i] = 0;
      row_size[i] = 0;
    end
    mem_words = 1024;
    holes_reset();
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: zero size, no fit, exact fit, unknown owner, merges
    queue_item(ffsa_pkg::OP_ALLOC, 0, 0, 0);
    queue_item(ffsa_pkg::OP_ALLOC, 255, 100, 0);
    queue_item(ffsa_pkg::OP_ALLOC, 1, 65535, 65535);
    queue_item(ffsa_pkg::OP_CHECK, 255, 0, 0);
    queue_item(ffsa_pkg::OP_CHECK, 255, 0, 99);
    queue_item(ffsa_pkg::OP_CHECK, 255, 0, 100);
    queue_item(ffsa_pkg::OP_CHECK, 255, 65535, 65535);
    queue_item(ffsa_pkg::OP_BASE, 255, 0, 0);
    queue_item(ffsa_pkg::OP_BASE, 7, 0, 0);
    queue_item(ffsa_pkg::OP_FREE, 7, 0, 0);
    queue_item(ffsa_pkg::OP_CHECK, 7, 0, 5);
    queue_item(ffsa_pkg::OP_ALLOC, 2, 50, 0);
    queue_item(ffsa_pkg::OP_ALLOC, 3, 874, 0);
    queue_item(ffsa_pkg::OP_ALLOC, 4, 1, 0);
    queue_item(ffsa_pkg::OP_CHECK, 3, 0, 1023);
    queue_item(ffsa_pkg::OP_FREE, 2, 0, 0);
    queue_item(ffsa_pkg::OP_FREE, 255, 0, 0);
    queue_item(ffsa_pkg::OP_FREE, 3, 0, 0);
    queue_item(ffsa_pkg::OP_ALLOC, 5, 1024, 0);
    queue_item(ffsa_pkg::OP_BASE, 5, 0, 0);
    wait_drained();

    // random phases over several memory sizes, table contents carried over
    sizes = '{65535, 1, 0, 1024, 300, 0};
    sizes[5] = $urandom_range(2, 65535);
    for (int p = 0; p < 7; p++) begin
      write_mem_size(p < 6 ? sizes[p] : 1024);
      quiet_mode = (p == 3);
      if (p == 4) hold_off = 400;
      for (int n = 0; n < 200; n++) begin
        queue_random();
        if (n == 100) wait_drained();
      end
      wait_drained();
    end

    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
